// ===== design/iafp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU angle frame parser package
// Shared types and constants for the angle frame parser.
// ----------------------------------------------------------------------------
package iafp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned NUM_ANGLE_BYTES = 6;
  localparam int unsigned ANGLE_IDX_W = 3;
  localparam int unsigned PROD_W    = ANGLE_W + BYTE_W;

  // Frame byte positions
  localparam logic [POS_W-1:0] POS_HEADER      = 4'd0;
  localparam logic [POS_W-1:0] POS_TYPE        = 4'd1;
  localparam logic [POS_W-1:0] POS_ANGLE_FIRST = 4'd2;
  localparam logic [POS_W-1:0] POS_ANGLE_LAST  = 4'd7;
  localparam logic [POS_W-1:0] POS_FRAME_LAST  = 4'd10;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_BYTE   = 1'd1;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h55;
  localparam logic [BYTE_W-1:0] TYPE_RESET   = 8'h53;

  // Degrees per full scale: raw * 180 / 256 gives Q9.7 degrees
  localparam logic [BYTE_W-1:0] DEG_SCALE = 8'd180;
  localparam int unsigned       DEG_SHIFT = 8;

  typedef struct packed {
    logic               done;
    logic               checksum_ok;
    logic [ANGLE_W-1:0] roll_raw;
    logic [ANGLE_W-1:0] pitch_raw;
    logic [ANGLE_W-1:0] yaw_raw;
  } frame_info_t;

endpackage

// ===== design/iafp_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU angle frame parser framer
// Tracks the byte position, the running byte sum and the angle bytes.
// ----------------------------------------------------------------------------
module iafp_framer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        byte_vld,
  input  logic                        byte_take,
  input  logic [iafp_pkg::BYTE_W-1:0] byte_data,
  input  logic [iafp_pkg::BYTE_W-1:0] header_byte,
  input  logic [iafp_pkg::BYTE_W-1:0] type_byte,
  output iafp_pkg::frame_info_t       frame
);

  logic [iafp_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [iafp_pkg::BYTE_W-1:0] sum_r, sum_nxt;
  logic [iafp_pkg::BYTE_W-1:0] angle_r [iafp_pkg::NUM_ANGLE_BYTES];
  logic                        at_last;
  logic                        angle_wr;
  logic [iafp_pkg::ANGLE_IDX_W-1:0] angle_idx;

  assign at_last  = (pos_r == iafp_pkg::POS_FRAME_LAST);
  assign angle_wr = byte_take && (pos_r >= iafp_pkg::POS_ANGLE_FIRST) &&
                    (pos_r <= iafp_pkg::POS_ANGLE_LAST);
  assign angle_idx = iafp_pkg::ANGLE_IDX_W'(pos_r - iafp_pkg::POS_ANGLE_FIRST);

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (byte_take) begin
      if (pos_r == iafp_pkg::POS_HEADER || pos_r > iafp_pkg::POS_FRAME_LAST) begin
        if (byte_data == header_byte) begin
          sum_nxt = byte_data;
          pos_nxt = iafp_pkg::POS_TYPE;
        end else begin
          pos_nxt = iafp_pkg::POS_HEADER;
        end
      end else if (pos_r == iafp_pkg::POS_TYPE) begin
        // Drop back on a wrong type byte; do not retest it as a header
        if (byte_data == type_byte) begin
          sum_nxt = sum_r + byte_data;
          pos_nxt = iafp_pkg::POS_ANGLE_FIRST;
        end else begin
          pos_nxt = iafp_pkg::POS_HEADER;
        end
      end else if (!at_last) begin
        sum_nxt = sum_r + byte_data;
        pos_nxt = pos_r + 4'd1;
      end else begin
        sum_nxt = '0;
        pos_nxt = iafp_pkg::POS_HEADER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= iafp_pkg::POS_HEADER;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (angle_wr) begin
      angle_r[angle_idx] <= byte_data;
    end
  end

  assign frame.done        = byte_vld && at_last;
  assign frame.checksum_ok = (sum_r == byte_data);
  assign frame.roll_raw    = {angle_r[1], angle_r[0]};
  assign frame.pitch_raw   = {angle_r[3], angle_r[2]};
  assign frame.yaw_raw     = {angle_r[5], angle_r[4]};

endmodule

// ===== design/iafp_deg_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU angle frame parser degree converter
// Scales a raw 16-bit angle to unsigned Q9.7 degrees: raw * 180 / 256.
// ----------------------------------------------------------------------------
module iafp_deg_conv (
  input  logic [iafp_pkg::ANGLE_W-1:0] raw,
  output logic [iafp_pkg::ANGLE_W-1:0] deg
);

  logic [iafp_pkg::PROD_W-1:0] prod;

  assign prod = iafp_pkg::PROD_W'(raw) * iafp_pkg::PROD_W'(iafp_pkg::DEG_SCALE);
  assign deg  = prod[iafp_pkg::DEG_SHIFT +: iafp_pkg::ANGLE_W];

endmodule

// ===== design/imu_angle_frame_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU angle frame parser
// Frames 11-byte angle packets from a serial byte stream and emits angles.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received byte per transaction (in_valid / in_ready).
//   out_* : one result per complete frame (out_valid / out_ready): checksum
//           flag plus roll, pitch and yaw in unsigned Q9.7 degrees.
//   cfg_* : write port; index 0 sets the header byte, index 1 the type byte.
//           cfg_ready is always high. Write only while the block is idle.
// Path: an accepted byte is held in the input register; a closing byte moves
//   on to the result register once that register is free.
// Throughput: one byte per cycle unless a closing byte is held back, set by the
//   single input register stage feeding the result register.
// Reset: position and byte sum clear, header/type return to 0x55/0x53,
//   both stages drop their contents.
// Stall: while out_ready is low with a result waiting, non-closing bytes
//   still advance; a closing byte holds in the input register, and in_ready
//   drops only then.
// ----------------------------------------------------------------------------
module imu_angle_frame_parser_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [iafp_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_checksum_ok,
  output logic [iafp_pkg::ANGLE_W-1:0]   out_roll_deg,
  output logic [iafp_pkg::ANGLE_W-1:0]   out_pitch_deg,
  output logic [iafp_pkg::ANGLE_W-1:0]   out_yaw_deg,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [iafp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iafp_pkg::BYTE_W-1:0]    cfg_wdata
);

  logic [iafp_pkg::BYTE_W-1:0]  header_r, type_r;
  logic                         s1_vld_r;
  logic [iafp_pkg::BYTE_W-1:0]  s1_byte_r;
  logic                         s1_fire;
  logic                         out_free;
  logic                         in_fire;
  iafp_pkg::frame_info_t        frame;
  logic [iafp_pkg::ANGLE_W-1:0] roll_deg, pitch_deg, yaw_deg;

  // Configuration registers: always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= iafp_pkg::HEADER_RESET;
      type_r   <= iafp_pkg::TYPE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        iafp_pkg::CFG_HEADER_BYTE: header_r <= cfg_wdata;
        iafp_pkg::CFG_TYPE_BYTE:   type_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register advances unless it holds a closing byte and the
  // result register is still occupied
  assign out_free = !out_valid || out_ready;
  assign s1_fire  = s1_vld_r && (!frame.done || out_free);
  assign in_ready = !s1_vld_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  iafp_framer u_framer (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_vld    (s1_vld_r),
    .byte_take   (s1_fire),
    .byte_data   (s1_byte_r),
    .header_byte (header_r),
    .type_byte   (type_r),
    .frame       (frame)
  );

  iafp_deg_conv u_roll  (.raw(frame.roll_raw),  .deg(roll_deg));
  iafp_deg_conv u_pitch (.raw(frame.pitch_raw), .deg(pitch_deg));
  iafp_deg_conv u_yaw   (.raw(frame.yaw_raw),   .deg(yaw_deg));

  // Result register: load on a closing byte, clear when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s1_fire && frame.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && frame.done) begin
      out_checksum_ok <= frame.checksum_ok;
      out_roll_deg    <= roll_deg;
      out_pitch_deg   <= pitch_deg;
      out_yaw_deg     <= yaw_deg;
    end
  end

endmodule

// ===== design/iafp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU angle frame parser checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module iafp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_checksum_ok,
  input logic [iafp_pkg::ANGLE_W-1:0]   out_roll_deg,
  input logic [iafp_pkg::ANGLE_W-1:0]   out_pitch_deg,
  input logic [iafp_pkg::ANGLE_W-1:0]   out_yaw_deg,
  input logic                           cfg_ready
);

  localparam logic [iafp_pkg::ANGLE_W-1:0] DEG_MAX = 16'd46079;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_checksum_ok) &&
      $stable(out_roll_deg) && $stable(out_pitch_deg) && $stable(out_yaw_deg))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An empty result register never blocks the input side
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready && cfg_ready)
    else $error("input stalled with empty result register");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_roll_deg <= DEG_MAX && out_pitch_deg <= DEG_MAX &&
      out_yaw_deg <= DEG_MAX)
    else $error("angle beyond full scale");

endmodule

bind imu_angle_frame_parser_unit iafp_checker u_iafp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_checksum_ok (out_checksum_ok),
  .out_roll_deg    (out_roll_deg),
  .out_pitch_deg   (out_pitch_deg),
  .out_yaw_deg     (out_yaw_deg),
  .cfg_ready       (cfg_ready)
);

// ===== bench/tb_imu_angle_frame_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU angle frame parser testbench
// Runs a short table of directed bytes, then random framed byte streams under
// several header/type settings and idle patterns. Every result transaction
// is checked against the directed table or a frame tracker built into this bench.
// ----------------------------------------------------------------------------
module tb_imu_angle_frame_parser_unit;

  localparam int unsigned HALF_PERIOD      = 6;
  localparam int unsigned DRAIN_CYCLES     = 4;
  localparam int unsigned NUM_DIRECTED     = 26;
  localparam int unsigned NUM_PHASES       = 5;
  localparam int unsigned BYTES_PER_PHASE  = 70;
  localparam int unsigned FRAMES_PER_PHASE = 6;
  localparam logic [iafp_pkg::ANGLE_W-1:0] DEG_MAX = 16'd46079;

  typedef logic [iafp_pkg::BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic                         checksum_ok;
    logic [iafp_pkg::ANGLE_W-1:0] roll_deg;
    logic [iafp_pkg::ANGLE_W-1:0] pitch_deg;
    logic [iafp_pkg::ANGLE_W-1:0] yaw_deg;
  } angles_t;

  // One directed byte; when typed is set, the frame it closes expects angles.
  typedef struct packed {
    byte_t   rx_byte;
    logic    typed;
    angles_t angles;
  } table_row_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam angles_t NO_FRAME = '0;
  localparam angles_t ZERO_OK  = '{1'b1, 16'd0, 16'd0, 16'd0};
  localparam angles_t MAX_BAD  = '{1'b0, DEG_MAX, DEG_MAX, DEG_MAX};

  // Directed bytes, all under the reset header 0x55 and type 0x53.
  localparam table_row_t DIRECTED [NUM_DIRECTED] = '{
    // header mismatch: dropped, stay at the header position
    '{8'h00, 1'b0, NO_FRAME},
    // header then a type mismatch that repeats the header value: must not resync
    '{8'h55, 1'b0, NO_FRAME},
    '{8'h55, 1'b0, NO_FRAME},
    // type value seen at the header position: dropped
    '{8'h53, 1'b0, NO_FRAME},
    // all-zero angles, good checksum 0x55 + 0x53 = 0xA8
    '{8'h55, 1'b0, NO_FRAME},
    '{8'h53, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'hA8, 1'b1, ZERO_OK},
    // full-scale angles with a bad checksum: result still comes, flag low
    '{8'h55, 1'b0, NO_FRAME},
    '{8'h53, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b1, MAX_BAD}
  };

  // --------------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_valid   = 1'b0;
  logic                           in_ready;
  byte_t                          in_rx_byte = '0;
  logic                           out_valid;
  logic                           out_ready  = 1'b0;
  logic                           out_checksum_ok;
  logic [iafp_pkg::ANGLE_W-1:0]   out_roll_deg;
  logic [iafp_pkg::ANGLE_W-1:0]   out_pitch_deg;
  logic [iafp_pkg::ANGLE_W-1:0]   out_yaw_deg;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [iafp_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  byte_t                          cfg_wdata  = '0;

  // --------------------------------------------------------------------------
  // Frame tracker state, mirrors the block's registers
  // --------------------------------------------------------------------------
  byte_t                      hdr_value  = iafp_pkg::HEADER_RESET;
  byte_t                      type_value = iafp_pkg::TYPE_RESET;
  logic [iafp_pkg::POS_W-1:0] frame_pos  = iafp_pkg::POS_HEADER;
  byte_t                      frame_sum  = '0;
  byte_t                      angle_store [iafp_pkg::NUM_ANGLE_BYTES];

  angles_t     expected_angles [$];   // one entry per closed frame, oldest first
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned framed_bytes  = 0;     // bytes that were not dropped at the header
  int unsigned frames_closed = 0;
  int unsigned fail_cnt      = 0;

  imu_angle_frame_parser_unit dut (.*);

  always #(HALF_PERIOD) clk = ~clk;

  // Stall the result channel at random; one assignment per edge.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // Scale a little-endian 16-bit raw angle to Q9.7 degrees: raw * 180 / 256.
  function automatic logic [iafp_pkg::ANGLE_W-1:0] raw_to_deg(input byte_t lo,
                                                              input byte_t hi);
    logic [iafp_pkg::PROD_W-1:0] prod;
    prod = {8'd0, hi, lo} * 24'd180;
    return prod[iafp_pkg::PROD_W-1:8];
  endfunction

  // Advance the frame tracker by one byte. Return 1 when the byte closes a
  // frame, with the angles in res; framed is 0 when the byte is dropped.
  function automatic bit track_byte(input byte_t b, output angles_t res, output bit framed);
    logic [iafp_pkg::POS_W-1:0] pos;
    pos         = (frame_pos > iafp_pkg::POS_FRAME_LAST) ? iafp_pkg::POS_HEADER : frame_pos;
    res         = '0;
    framed      = 1'b1;
    track_byte  = 1'b0;
    if (pos == iafp_pkg::POS_HEADER) begin
      if (b == hdr_value) begin
        frame_sum = b;
        frame_pos = iafp_pkg::POS_TYPE;
      end else begin
        framed = 1'b0;
      end
    end else if (pos == iafp_pkg::POS_TYPE) begin
      // a wrong type byte restarts the hunt; it is never taken as a header
      if (b == type_value) begin
        frame_sum += b;
        frame_pos = iafp_pkg::POS_ANGLE_FIRST;
      end else begin
        frame_pos = iafp_pkg::POS_HEADER;
      end
    end else if (pos < iafp_pkg::POS_FRAME_LAST) begin
      if (pos <= iafp_pkg::POS_ANGLE_LAST) begin
        angle_store[iafp_pkg::ANGLE_IDX_W'(pos - iafp_pkg::POS_ANGLE_FIRST)] = b;
      end
      frame_sum += b;
      frame_pos = pos + 1'b1;
    end else begin
      res.checksum_ok = (frame_sum == b);
      res.roll_deg    = raw_to_deg(angle_store[0], angle_store[1]);
      res.pitch_deg   = raw_to_deg(angle_store[2], angle_store[3]);
      res.yaw_deg     = raw_to_deg(angle_store[4], angle_store[5]);
      frame_pos       = iafp_pkg::POS_HEADER;
      frame_sum       = '0;
      track_byte      = 1'b1;
    end
  endfunction

  // Drive one byte transaction, idling first at random. Hold valid high
  // between back-to-back bytes; lower it only on an idle cycle.
  task automatic send_byte(input byte_t b, input logic typed, input angles_t typed_res);
    angles_t res;
    bit      framed;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (track_byte(b, res, framed)) begin
      expected_angles.push_back(typed ? typed_res : res);
      frames_closed++;
    end
    if (framed) framed_bytes++;
  endtask

  // Hold the input idle until every expected result is out, then let the
  // block settle for its pipeline depth.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write header and type registers back to back; only call while idle.
  task automatic write_config(input byte_t hdr, input byte_t typ);
    cfg_valid <= 1'b1;
    cfg_index <= iafp_pkg::CFG_HEADER_BYTE;
    cfg_wdata <= hdr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    hdr_value = hdr;
    cfg_index <= iafp_pkg::CFG_TYPE_BYTE;
    cfg_wdata <= typ;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    type_value = typ;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Send a well-formed frame with random payload; corrupt the checksum
  // when sum_good is clear.
  task automatic send_frame(input bit sum_good);
    byte_t sum;
    byte_t b;
    sum = hdr_value + type_value;
    send_byte(hdr_value, 1'b0, NO_FRAME);
    send_byte(type_value, 1'b0, NO_FRAME);
    repeat (8) begin
      b = byte_t'($urandom_range(255, 0));
      sum += b;
      send_byte(b, 1'b0, NO_FRAME);
    end
    if (!sum_good) sum ^= byte_t'($urandom_range(255, 1));
    send_byte(sum, 1'b0, NO_FRAME);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: compare every result transaction with the oldest frame
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    angles_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_angles.size() == 0) begin
        $error("unexpected result: checksum_ok=%0d roll=%0d pitch=%0d yaw=%0d",
               out_checksum_ok, out_roll_deg, out_pitch_deg, out_yaw_deg);
        fail_cnt++;
      end else begin
        want = expected_angles.pop_front();
        if (out_checksum_ok !== want.checksum_ok) begin
          $error("checksum_ok: expected %0d, got %0d", want.checksum_ok, out_checksum_ok);
          fail_cnt++;
        end
        if (out_roll_deg !== want.roll_deg) begin
          $error("roll_deg: expected %0d, got %0d", want.roll_deg, out_roll_deg);
          fail_cnt++;
        end
        if (out_pitch_deg !== want.pitch_deg) begin
          $error("pitch_deg: expected %0d, got %0d", want.pitch_deg, out_pitch_deg);
          fail_cnt++;
        end
        if (out_yaw_deg !== want.yaw_deg) begin
          $error("yaw_deg: expected %0d, got %0d", want.yaw_deg, out_yaw_deg);
          fail_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    idle_mode_t  mode;
    int unsigned pick;
    int unsigned byte_mark;
    int unsigned frame_mark;
    byte_t       bad_type;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table under the reset register values, no idling.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_byte(DIRECTED[i].rx_byte, DIRECTED[i].typed, DIRECTED[i].angles);
    end

    // Random phases: each one drains, picks an idle pattern, rewrites both
    // registers, then streams mostly well-formed frames with some noise.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      mode = idle_mode_t'(p % 4);
      case (mode)
        IDLE_NONE: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        IDLE_SENDER: begin
          send_idle_pct = 47;
          stall_pct     = 0;
        end
        IDLE_RECEIVER: begin
          send_idle_pct = 0;
          stall_pct     = 47;
        end
        default: begin
          send_idle_pct = 10;
          stall_pct     = 10;
        end
      endcase
      case (p)
        0: write_config(8'h00, 8'hFF);
        1: write_config(8'hFF, 8'h00);
        2: write_config(byte_t'($urandom_range(255, 0)), byte_t'($urandom_range(255, 0)));
        3: write_config(8'hA5, 8'hA5);   // header and type equal
        default: write_config(iafp_pkg::HEADER_RESET, iafp_pkg::TYPE_RESET);
      endcase

      byte_mark  = framed_bytes;
      frame_mark = frames_closed;
      while (framed_bytes - byte_mark < BYTES_PER_PHASE ||
             frames_closed - frame_mark < FRAMES_PER_PHASE) begin
        pick = $urandom_range(99, 0);
        if (pick < 3) begin
          // pause the sender until the result channel is empty
          drain_results();
        end else if (pick < 70) begin
          send_frame(1'b1);
        end else if (pick < 80) begin
          send_frame(1'b0);
        end else if (pick < 90) begin
          // broken start: header followed by a wrong type byte
          if (hdr_value != type_value && $urandom_range(1, 0) == 1) begin
            bad_type = hdr_value;
          end else begin
            do bad_type = byte_t'($urandom_range(255, 0)); while (bad_type == type_value);
          end
          send_byte(hdr_value, 1'b0, NO_FRAME);
          send_byte(bad_type, 1'b0, NO_FRAME);
        end else begin
          repeat ($urandom_range(3, 1)) begin
            send_byte(byte_t'($urandom_range(255, 0)), 1'b0, NO_FRAME);
          end
        end
      end
    end

    // Wait out every expected result plus the pipeline depth.
    drain_results();
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[imu_angle_frame_parser_unit] OK");
    end else begin
      $display("[imu_angle_frame_parser_unit] ERROR");
    end
    $finish;
  end

  // Timeout far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("[imu_angle_frame_parser_unit] ERROR");
    $finish;
  end

endmodule
